// ===== design/bmhq_pkg.sv =====
package bmhq_pkg;

	localparam int KEY_W = 32;
	localparam int TAG_W = 32;
	localparam int ENTRY_W = KEY_W + TAG_W;
	localparam int IN_W = ((KEY_W + TAG_W + 7) / 8) * 8;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic signed [KEY_W-1:0] key;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_CMP,
		ST_RM_LAST,
		ST_RM_SET,
		ST_DN_ISSUE,
		ST_DN_RIGHT,
		ST_DN_CMP,
		ST_WR_CUR,
		ST_DONE
	} state_t;

	function automatic logic key_less(input entry_t a, input entry_t b);
		return $signed(a.key) < $signed(b.key);
	endfunction

endpackage

// ===== design/bmhq_ram.sv =====
module bmhq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/binary_min_heap_queue_core.sv =====
// Insert: the new entry climbs from the first free slot, one RAM read per level, while it is
// smaller than its parent; its result then enters the output register.
// Remove-min: the last entry moves to the root and sinks while a child is smaller, with
// two RAM reads per level (left child, then right child); it does not sink when at most one entry is left.
// A failed operation goes straight to the output stage; the next item is accepted once the previous result has
// entered the output register. Reset empties the queue (count to zero), not the entry RAM.
module binary_min_heap_queue_core import bmhq_pkg::*; #(
	parameter int CAPACITY = 64,
	localparam int CNT_W = $clog2(CAPACITY + 1),
	localparam int OUT_W = ((KEY_W + TAG_W + CNT_W + 7) / 8) * 8
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [IN_W-1:0] s_axis_tdata,     // entry_key, entry_tag
	input logic s_axis_tuser,                // operation
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata,   // removed_key, removed_tag, element_count
	output logic [1:0] m_axis_tuser          // status
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CHW = AW + 2;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [AW-1:0] pos_q, pos_d;
	logic [AW-1:0] kid_idx_q, kid_idx_d;
	logic has_right_q, has_right_d;
	entry_t cur_q, cur_d;
	entry_t kid_q, kid_d;
	logic [1:0] res_status_q, res_status_d;
	logic [KEY_W-1:0] res_key_q, res_key_d;
	logic [TAG_W-1:0] res_tag_q, res_tag_d;
	logic out_load;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	entry_t ram_wdata, rd_entry;
	logic [ENTRY_W-1:0] ram_rdata;

	entry_t in_entry;
	logic [AW-1:0] ins_pos, par_ins, par_pos, par_par;
	logic right_wins;
	entry_t pick_entry;
	logic [AW-1:0] pick_idx, dn_pos;
	logic [CHW-1:0] dn_left, dn_right, cnt_ext;
	logic dn_left_ok, dn_right_ok;

	bmhq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_entry = ram_rdata;
	assign in_entry.key = s_axis_tdata[KEY_W-1:0];
	assign in_entry.tag = s_axis_tdata[KEY_W+TAG_W-1:KEY_W];
	assign s_axis_tready = (state_q == ST_IDLE);

	assign ins_pos = count_q[AW-1:0];
	assign par_ins = (ins_pos - 1'b1) >> 1;
	assign par_pos = (pos_q - 1'b1) >> 1;
	assign par_par = (par_pos - 1'b1) >> 1;

	// The right child wins only when strictly smaller; equal keys keep the left child.
	assign right_wins = has_right_q && key_less(rd_entry, kid_q);
	assign pick_entry = right_wins ? rd_entry : kid_q;
	assign pick_idx = right_wins ? kid_idx_q + 1'b1 : kid_idx_q;

	assign dn_pos = (state_q == ST_DN_CMP) ? pick_idx : pos_q;
	assign dn_left = {1'b0, dn_pos, 1'b1};
	assign dn_right = dn_left + 1'b1;
	assign cnt_ext = CHW'(count_q);
	assign dn_left_ok = dn_left < cnt_ext;
	assign dn_right_ok = dn_right < cnt_ext;

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		pos_d = pos_q;
		kid_idx_d = kid_idx_q;
		has_right_d = has_right_q;
		cur_d = cur_q;
		kid_d = kid_q;
		res_status_d = res_status_q;
		res_key_d = res_key_q;
		res_tag_d = res_tag_q;
		out_load = 1'b0;
		ram_we = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = cur_q;
		ram_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					res_key_d = '0;
					res_tag_d = '0;
					res_status_d = STATUS_OK;
					if (s_axis_tuser == OP_INSERT) begin
						if (count_q == CAP_C) begin
							res_status_d = STATUS_FULL;
							state_d = ST_DONE;
						end else begin
							cur_d = in_entry;
							pos_d = ins_pos;
							count_d = count_q + 1'b1;
							ram_raddr = par_ins;
							state_d = (ins_pos == '0) ? ST_WR_CUR : ST_UP_CMP;
						end
					end else begin
						if (count_q == '0) begin
							res_status_d = STATUS_EMPTY;
							state_d = ST_DONE;
						end else begin
							count_d = count_q - 1'b1;
							ram_raddr = '0;
							state_d = ST_RM_LAST;
						end
					end
				end
			end
			ST_UP_CMP: begin
				// The hole climbs: the parent moves down while the new key is smaller.
				if (key_less(cur_q, rd_entry)) begin
					ram_we = 1'b1;
					ram_wdata = rd_entry;
					pos_d = par_pos;
					ram_raddr = par_par;
					state_d = (par_pos == '0) ? ST_WR_CUR : ST_UP_CMP;
				end else begin
					ram_we = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_RM_LAST: begin
				res_key_d = rd_entry.key;
				res_tag_d = rd_entry.tag;
				ram_raddr = count_q[AW-1:0];
				state_d = ST_RM_SET;
			end
			ST_RM_SET: begin
				cur_d = rd_entry;
				pos_d = '0;
				state_d = (count_q == '0) ? ST_DONE : ST_DN_ISSUE;
			end
			ST_DN_ISSUE: begin
				if (dn_left_ok) begin
					ram_raddr = dn_left[AW-1:0];
					kid_idx_d = dn_left[AW-1:0];
					has_right_d = dn_right_ok;
					state_d = ST_DN_RIGHT;
				end else begin
					ram_we = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DN_RIGHT: begin
				kid_d = rd_entry;
				ram_raddr = kid_idx_q + 1'b1;
				state_d = ST_DN_CMP;
			end
			ST_DN_CMP: begin
				ram_we = 1'b1;
				if (key_less(pick_entry, cur_q)) begin
					ram_wdata = pick_entry;
					pos_d = pick_idx;
					if (dn_left_ok) begin
						ram_raddr = dn_left[AW-1:0];
						kid_idx_d = dn_left[AW-1:0];
						has_right_d = dn_right_ok;
						state_d = ST_DN_RIGHT;
					end else begin
						state_d = ST_WR_CUR;
					end
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_WR_CUR: begin
				ram_we = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pos_q <= '0;
			kid_idx_q <= '0;
			has_right_q <= 1'b0;
			res_status_q <= STATUS_OK;
			m_axis_tvalid <= 1'b0;
			m_axis_tuser <= STATUS_OK;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pos_q <= pos_d;
			kid_idx_q <= kid_idx_d;
			has_right_q <= has_right_d;
			res_status_q <= res_status_d;
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
				m_axis_tuser <= res_status_q;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		kid_q <= kid_d;
		res_key_q <= res_key_d;
		res_tag_q <= res_tag_d;
		if (out_load) begin
			m_axis_tdata <= OUT_W'({count_q, res_tag_q, res_key_q});
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count beyond capacity");

	a_write_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> CNT_W'(ram_waddr) < count_q)
		else $error("entry written outside the occupied part of the heap");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_INSERT && count_q != CAP_C
		|=> count_q == CNT_W'($past(count_q) + 1'b1))
		else $error("insert did not grow the count");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_REMOVE && count_q != '0
		|=> count_q == CNT_W'($past(count_q) - 1'b1))
		else $error("remove did not shrink the count");

	a_failed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != STATUS_OK |-> m_axis_tdata[KEY_W+TAG_W-1:0] == '0)
		else $error("failed operation reports a nonzero entry");

endmodule

// ===== verif/binary_min_heap_queue_core_tb.sv =====
`timescale 1ns / 100ps

module binary_min_heap_queue_core_tb import bmhq_pkg::*; ();

	localparam int QUEUE_DEPTH = 64;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_W = ((KEY_W + TAG_W + CNT_W + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 1000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [1:0] status;
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic [CNT_W-1:0] count;
	} heap_result_t;

	typedef struct packed {
		logic op;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		logic known;
		heap_result_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	entry_t heap_mem [QUEUE_DEPTH];
	int held;
	heap_result_t pending_results [$];
	stim_row_t plan [$];

	int errors;
	int send_idle_pct;
	int recv_idle_pct;
	bit stall_request;
	int inserts_ok, removes_ok, full_hits, empty_hits, peak_held;

	binary_min_heap_queue_core #(
		.CAPACITY(QUEUE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic key_before(input entry_t a, input entry_t b);
		return $signed(a.key) < $signed(b.key);
	endfunction

	function automatic void swap_entries(input int a, input int b);
		entry_t tmp;
		tmp = heap_mem[a];
		heap_mem[a] = heap_mem[b];
		heap_mem[b] = tmp;
	endfunction

	// Applies one item to the local copy of the heap and returns the result it should give.
	function automatic heap_result_t heap_step(input logic op, input logic [KEY_W-1:0] key,
			input logic [TAG_W-1:0] tag);
		heap_result_t r;
		int pos, up, lc, rc, pick;
		r = '0;
		r.status = STATUS_OK;
		if (op == OP_INSERT) begin
			if (held >= QUEUE_DEPTH) begin
				r.status = STATUS_FULL;
				full_hits++;
			end else begin
				pos = held;
				heap_mem[pos].key = key;
				heap_mem[pos].tag = tag;
				held++;
				inserts_ok++;
				while (pos != 0) begin
					up = (pos - 1) / 2;
					if (!key_before(heap_mem[pos], heap_mem[up]))
						break;
					swap_entries(pos, up);
					pos = up;
				end
			end
		end else begin
			if (held == 0) begin
				r.status = STATUS_EMPTY;
				empty_hits++;
			end else begin
				r.key = heap_mem[0].key;
				r.tag = heap_mem[0].tag;
				held--;
				removes_ok++;
				heap_mem[0] = heap_mem[held];
				pos = 0;
				while (1) begin
					lc = 2 * pos + 1;
					rc = lc + 1;
					if (lc >= held)
						break;
					pick = lc;
					if (rc < held && key_before(heap_mem[rc], heap_mem[lc]))
						pick = rc;
					if (!key_before(heap_mem[pick], heap_mem[pos]))
						break;
					swap_entries(pos, pick);
					pos = pick;
				end
			end
		end
		if (held > peak_held)
			peak_held = held;
		r.count = held[CNT_W-1:0];
		return r;
	endfunction

	task automatic add_row(input logic op, input logic [KEY_W-1:0] key,
			input logic [TAG_W-1:0] tag, input logic known, input logic [1:0] st,
			input logic [KEY_W-1:0] rk, input logic [TAG_W-1:0] rt, input int cnt);
		stim_row_t row;
		row.op = op;
		row.key = key;
		row.tag = tag;
		row.known = known;
		row.want.status = st;
		row.want.key = rk;
		row.want.tag = rt;
		row.want.count = cnt[CNT_W-1:0];
		plan.push_back(row);
	endtask

	// Offers one item, waits for it to be taken and records what it should produce.
	// A typed expectation replaces the predicted one, but the prediction still runs
	// so that the local heap stays in step with the block.
	task automatic offer_item(input logic op, input logic [KEY_W-1:0] key,
			input logic [TAG_W-1:0] tag, input logic known, input heap_result_t want);
		heap_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {tag, key};
		s_axis_tuser <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predicted = heap_step(op, key, tag);
		pending_results.push_back(known ? want : predicted);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		logic [KEY_W-1:0] k;
		case ($urandom_range(3))
			0: k = KEY_W'(int'($urandom_range(8)) - 4);
			1: begin
				case ($urandom_range(3))
					0: k = {1'b1, {(KEY_W-1){1'b0}}};
					1: k = {1'b0, {(KEY_W-1){1'b1}}};
					2: k = '0;
					default: k = '1;
				endcase
			end
			default: k = $urandom;
		endcase
		return k;
	endfunction

	// Random traffic in a cycle of fill, mixed, drain and mixed phases, so that the
	// heap is driven both to full and to empty with random keys in between.
	task automatic run_random(input int n_items);
		int sent, phase, len, remove_pct;
		logic op;
		sent = 0;
		phase = 0;
		while (sent < n_items) begin
			case (phase % 4)
				0: begin
					len = $urandom_range(90, 120);
					remove_pct = 10;
				end
				2: begin
					len = $urandom_range(90, 120);
					remove_pct = 90;
				end
				default: begin
					len = $urandom_range(20, 60);
					remove_pct = 50;
				end
			endcase
			repeat (len) begin
				op = ($urandom_range(99) < remove_pct) ? OP_REMOVE : OP_INSERT;
				offer_item(op, pick_key(), $urandom, 1'b0, '0);
				sent++;
			end
			phase++;
		end
	endtask

	initial begin
		errors = 0;
		held = 0;
		stall_request = 0;
		inserts_ok = 0;
		removes_ok = 0;
		full_hits = 0;
		empty_hits = 0;
		peak_held = 0;
		send_idle_pct = 26;
		recv_idle_pct = 46;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= OP_INSERT;
		m_axis_tready <= 1'b0;

		add_row(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, STATUS_EMPTY, 0, 0, 0);
		add_row(OP_REMOVE, 32'hffff_ffff, 32'hffff_ffff, 1'b1, STATUS_EMPTY, 0, 0, 0);
		add_row(OP_INSERT, 32'h7fff_ffff, 32'h0000_0000, 1'b1, STATUS_OK, 0, 0, 1);
		add_row(OP_INSERT, 32'h8000_0000, 32'hffff_ffff, 1'b1, STATUS_OK, 0, 0, 2);
		add_row(OP_INSERT, 32'h0000_0000, 32'h5555_5555, 1'b1, STATUS_OK, 0, 0, 3);
		add_row(OP_INSERT, 32'hffff_ffff, 32'haaaa_aaaa, 1'b1, STATUS_OK, 0, 0, 4);
		add_row(OP_INSERT, 32'hffff_ffff, 32'h0000_0001, 1'b1, STATUS_OK, 0, 0, 5);
		add_row(OP_INSERT, 32'h0000_0001, 32'h1234_5678, 1'b1, STATUS_OK, 0, 0, 6);
		add_row(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, STATUS_OK,
			32'h8000_0000, 32'hffff_ffff, 5);
		// Two equal keys: which tag leaves first is left to the predictor.
		add_row(OP_REMOVE, 32'h1234_5678, 32'h9abc_def0, 1'b0, STATUS_OK, 0, 0, 0);
		add_row(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, STATUS_OK, 0, 0, 0);
		add_row(OP_INSERT, 32'h8000_0000, 32'h0f0f_0f0f, 1'b1, STATUS_OK, 0, 0, 4);
		add_row(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, STATUS_OK,
			32'h8000_0000, 32'h0f0f_0f0f, 3);
		add_row(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, STATUS_OK, 0, 0, 0);
		add_row(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, STATUS_OK, 0, 0, 0);
		add_row(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, STATUS_OK,
			32'h7fff_ffff, 32'h0000_0000, 0);
		add_row(OP_REMOVE, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 1'b1, STATUS_EMPTY, 0, 0, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			offer_item(plan[i].op, plan[i].key, plan[i].tag, plan[i].known, plan[i].want);

		// The receiver stops for a long stretch at the start, so the block backs up.
		stall_request = 1;
		run_random(RANDOM_ITEMS / 3);
		send_idle_pct = 46;
		recv_idle_pct = 26;
		run_random(RANDOM_ITEMS / 3);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Covered %0d accepted inserts and %0d removals, peak occupancy %0d of %0d.",
			inserts_ok, removes_ok, peak_held, QUEUE_DEPTH);
		$display("Rejected %0d inserts into a full queue and %0d removals from an empty one.",
			full_hits, empty_hits);
		if (errors == 0) begin
			$display("binary_min_heap_queue_core test passed");
		end else begin
			$display("binary_min_heap_queue_core test failed");
		end
		$finish;
	end

	// Result side: checks each accepted item and decides the next ready.
	initial begin
		heap_result_t exp;
		heap_result_t got;
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.status = m_axis_tuser;
				got.key = m_axis_tdata[KEY_W-1:0];
				got.tag = m_axis_tdata[KEY_W +: TAG_W];
				got.count = m_axis_tdata[KEY_W + TAG_W +: CNT_W];
				if (pending_results.size() == 0) begin
					$error("result arrived with nothing pending");
					errors++;
				end else begin
					exp = pending_results.pop_front();
					if (got.status !== exp.status) begin
						$error("status: expected %0d, got %0d", exp.status, got.status);
						errors++;
					end
					if (got.key !== exp.key) begin
						$error("removed_key: expected %0d, got %0d", exp.key, got.key);
						errors++;
					end
					if (got.tag !== exp.tag) begin
						$error("removed_tag: expected %h, got %h", exp.tag, got.tag);
						errors++;
					end
					if (got.count !== exp.count) begin
						$error("element_count: expected %0d, got %0d", exp.count, got.count);
						errors++;
					end
				end
			end
			if (stall_request) begin
				stall_request = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("binary_min_heap_queue_core test failed");
		$finish;
	end

endmodule
